// ----- src/rg2pp_pkg.sv -----
// ----------------------------------------------------------------------------
// rg2pp_pkg: shared types and constants of the 2-bit gray pixel packer
// Word kinds, the result word layout, the push group between the packing
// logic and the output queue, and the luma quantizer thresholds.
// ----------------------------------------------------------------------------
package rg2pp_pkg;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_MASK = 1'b1
   } byte_kind_type;

   typedef struct packed {
      byte_kind_type kind;
      logic [7:0]    byte_value;
      logic          mask_used;
      logic          run_end;
   } rsp_word_type;

   // Zero, one or two result words produced by one pixel, in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   localparam int LUMA_SUM_W = 12;   // blue + 6*green + 3*red peaks at 2550
   localparam int LUMA_DIV   = 10;

   // Quantizer thresholds on the truncated luma, moved onto the undivided
   // weighted sum: luma <= T holds exactly when sum <= 10*T + 9.
   localparam int GRAY_T0 = 'h2a;
   localparam int GRAY_T1 = 'h80;
   localparam int GRAY_T2 = 'hd4;
   localparam logic [LUMA_SUM_W-1:0] SUM_MAX_0 =
      LUMA_SUM_W'(GRAY_T0 * LUMA_DIV + LUMA_DIV - 1);
   localparam logic [LUMA_SUM_W-1:0] SUM_MAX_1 =
      LUMA_SUM_W'(GRAY_T1 * LUMA_DIV + LUMA_DIV - 1);
   localparam logic [LUMA_SUM_W-1:0] SUM_MAX_2 =
      LUMA_SUM_W'(GRAY_T2 * LUMA_DIV + LUMA_DIV - 1);

   localparam logic [7:0] GRAY_EMPTY = 8'h00;
   localparam logic [7:0] MASK_EMPTY = 8'hff;

   localparam logic [2:0] PHASE_LAST_MASK = 3'd7;
   localparam logic [1:0] PHASE_LAST_DATA = 2'd3;

endpackage

// ----- src/rgb_to_gray2_pixel_packer.sv -----
// ----------------------------------------------------------------------------
// rgb_to_gray2_pixel_packer: RGB pixels to packed 2-bit gray plus mask
// Quantizes each opaque pixel to two bits of gray, packs four to a data
// byte and tracks transparency in a mask byte of eight pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and returns zero, one or two bytes per
// pixel: a data byte (kind 0) once four pixels are packed or at row end, and
// a mask byte (kind 1) once eight pixels are covered or at row end, the data
// byte first when a pixel closes both. A pixel is captured in an input
// register, then in the next cycle in which the queue has room the luma
// compare and the packing update run as one shallow step and the finished
// words go into a four-word output queue, from whose registers the result
// words are handed out in order on the output port. The pixel rate is one per
// clock as long as the output side takes one word per clock and, over any
// run of pixels, the words produced exceed the number of pixels by at most
// one; the queue accepts a pixel only when it has room for two words, so a
// run of pixels that each close both bytes (eight-pixel rows end that way
// every eighth pixel) settles at the output port's rate of one word per
// clock. Image start only clears the sticky mask flag; the packing phase
// carries on, so an image should begin right after a row end.
// ----------------------------------------------------------------------------
module rgb_to_gray2_pixel_packer (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_transparent,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       req_row_end,
   input  logic       req_image_start,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_mask_used,
   output logic       rsp_run_end
);

   // Input register: holds one pixel until the packing step consumes it.
   logic       pix_valid_ff, pix_valid_in;
   logic       pix_transparent_ff;
   logic [7:0] pix_red_ff;
   logic [7:0] pix_green_ff;
   logic [7:0] pix_blue_ff;
   logic       pix_row_end_ff;
   logic       pix_image_start_ff;

   // Packing state.
   logic [2:0] phase_ff, phase_in;
   logic [7:0] gray_ff, gray_in;
   logic [7:0] mask_ff, mask_in;
   logic       seen_ff, seen_in;

   logic       advance;
   logic       queue_room;
   logic       req_take;
   logic [1:0] gray2;
   logic [1:0] sub_phase;
   logic [7:0] gray_next;
   logic [7:0] mask_next;
   logic       seen_next;
   logic       emit_data;
   logic       emit_mask;
   rg2pp_pkg::rsp_word_type data_word;
   rg2pp_pkg::rsp_word_type mask_word;
   rg2pp_pkg::push_type     push;
   rg2pp_pkg::rsp_word_type out_word;

   // The held pixel is packed when the queue can take both possible words.
   assign advance   = pix_valid_ff && queue_room;
   assign req_ready = !pix_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   rg2pp_luma u_luma (
      .red   (pix_red_ff),
      .green (pix_green_ff),
      .blue  (pix_blue_ff),
      .gray2 (gray2)
   );

   // One packing step: merge the pixel, then decide which bytes close.
   always_comb begin
      sub_phase = phase_ff[1:0];
      seen_next = pix_transparent_ff || (seen_ff && !pix_image_start_ff);
      if (pix_transparent_ff) begin
         gray_next = gray_ff;
         mask_next = mask_ff & ~(8'h80 >> phase_ff);
      end else begin
         gray_next = gray_ff | ({6'b000000, gray2} << {~sub_phase, 1'b0});
         mask_next = mask_ff;
      end
      emit_data = (sub_phase == rg2pp_pkg::PHASE_LAST_DATA) || pix_row_end_ff;
      emit_mask = (phase_ff == rg2pp_pkg::PHASE_LAST_MASK) || pix_row_end_ff;

      data_word.kind       = rg2pp_pkg::KIND_DATA;
      data_word.byte_value = gray_next;
      data_word.mask_used  = seen_next;
      data_word.run_end    = !emit_mask;

      mask_word.kind       = rg2pp_pkg::KIND_MASK;
      mask_word.byte_value = mask_next;
      mask_word.mask_used  = seen_next;
      mask_word.run_end    = 1'b1;

      // The data byte always goes first when both close on one pixel.
      push.first  = emit_data ? data_word : mask_word;
      push.second = mask_word;
      if (!advance) begin
         push.count = 2'd0;
      end else begin
         push.count = {1'b0, emit_data} + {1'b0, emit_mask};
      end

      pix_valid_in = req_take || (pix_valid_ff && !advance);
      if (advance) begin
         phase_in = pix_row_end_ff ? 3'd0 : 3'(phase_ff + 3'd1);
         gray_in  = emit_data ? rg2pp_pkg::GRAY_EMPTY : gray_next;
         mask_in  = emit_mask ? rg2pp_pkg::MASK_EMPTY : mask_next;
         seen_in  = seen_next;
      end else begin
         phase_in = phase_ff;
         gray_in  = gray_ff;
         mask_in  = mask_ff;
         seen_in  = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         phase_ff     <= 3'd0;
         gray_ff      <= rg2pp_pkg::GRAY_EMPTY;
         mask_ff      <= rg2pp_pkg::MASK_EMPTY;
         seen_ff      <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         phase_ff     <= phase_in;
         gray_ff      <= gray_in;
         mask_ff      <= mask_in;
         seen_ff      <= seen_in;
      end
   end

   // Pixel payload needs no reset; it is loaded with every accepted pixel.
   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_transparent_ff <= req_transparent;
         pix_red_ff         <= req_red;
         pix_green_ff       <= req_green;
         pix_blue_ff        <= req_blue;
         pix_row_end_ff     <= req_row_end;
         pix_image_start_ff <= req_image_start;
      end
   end

   rg2pp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (queue_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_kind       = out_word.kind;
   assign rsp_byte_value = out_word.byte_value;
   assign rsp_mask_used  = out_word.mask_used;
   assign rsp_run_end    = out_word.run_end;

endmodule

// ----- src/rg2pp_luma.sv -----
// ----------------------------------------------------------------------------
// rg2pp_luma: RGB to 2-bit gray level
// Forms the weighted sum blue + 6*green + 3*red and compares it against the
// scaled thresholds, so no divider is needed.
// ----------------------------------------------------------------------------
module rg2pp_luma (
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output logic [1:0] gray2
);

   logic [rg2pp_pkg::LUMA_SUM_W-1:0] green_x6;
   logic [rg2pp_pkg::LUMA_SUM_W-1:0] red_x3;
   logic [rg2pp_pkg::LUMA_SUM_W-1:0] luma_sum;

   always_comb begin
      green_x6 = {3'b000, green, 1'b0} + {2'b00, green, 2'b00};
      red_x3   = {3'b000, red, 1'b0} + {4'b0000, red};
      luma_sum = {4'b0000, blue} + green_x6 + red_x3;
      if (luma_sum <= rg2pp_pkg::SUM_MAX_0) begin
         gray2 = 2'd0;
      end else if (luma_sum <= rg2pp_pkg::SUM_MAX_1) begin
         gray2 = 2'd1;
      end else if (luma_sum <= rg2pp_pkg::SUM_MAX_2) begin
         gray2 = 2'd2;
      end else begin
         gray2 = 2'd3;
      end
   end

endmodule

// ----- src/rg2pp_out_queue.sv -----
// ----------------------------------------------------------------------------
// rg2pp_out_queue: four-word result queue
// Takes up to two words per cycle from the packing logic and hands out one
// word per cycle on a valid/ready port while the consumer is ready.
// ----------------------------------------------------------------------------
module rg2pp_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rg2pp_pkg::push_type     push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rg2pp_pkg::rsp_word_type out_word
);

   rg2pp_pkg::rsp_word_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_ptr_next;

   assign pop         = out_valid && out_ready;
   assign out_valid   = (count_ff != 3'd0);
   assign out_word    = entry_ff[rd_ptr_ff];
   // Room for a full pair of words, judged from the registered count only.
   assign room        = (count_ff <= 3'd2);
   assign wr_ptr_next = 2'(wr_ptr_ff + 2'd1);

   always_comb begin
      wr_ptr_in = 2'(wr_ptr_ff + push.count);
      rd_ptr_in = 2'(rd_ptr_ff + {1'b0, pop});
      count_in  = 3'(count_ff + {1'b0, push.count} - {2'b00, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

// ----- src/rg2pp_checker.sv -----
// ----------------------------------------------------------------------------
// rg2pp_checker: port-level checks of the gray pixel packer
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module rg2pp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_byte_value,
   input logic       rsp_mask_used,
   input logic       rsp_run_end
);

   // A word that waits keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_byte_value) && $stable(rsp_mask_used) && $stable(rsp_run_end))
      else $error("result word changed while stalled");

   // Nothing is left to deliver right after reset, and a pixel can be taken.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result word valid or input not ready after reset");

   // A mask byte is always the last word caused by its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rg2pp_pkg::KIND_MASK) |-> rsp_run_end)
      else $error("mask byte without run end");

   // A data byte that is not last is followed at once by its mask byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == rg2pp_pkg::KIND_DATA) && !rsp_run_end
         |=> rsp_valid && (rsp_kind == rg2pp_pkg::KIND_MASK) && rsp_run_end)
      else $error("data byte not followed by its mask byte");

endmodule

bind rgb_to_gray2_pixel_packer rg2pp_checker u_rg2pp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_byte_value (rsp_byte_value),
   .rsp_mask_used  (rsp_mask_used),
   .rsp_run_end    (rsp_run_end)
);
